/* rtl/igmp_hgt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package igmp_hgt_pkg;

   localparam int TableRowsDefault = 8;
   localparam int MaxResults = 8;
   localparam logic [31:0] AllHostsGroup = 32'hE000_0001;
   localparam logic [31:0] LfsrTaps = 32'hD000_0001;
   localparam logic [15:0] IntervalReset = 16'd10000;
   localparam logic [31:0] SeedReset = 32'd1;
   localparam logic [6:0] RespUnit = 7'd100;

   // opcodes
   localparam logic [2:0] OP_TICK = 3'd0;
   localparam logic [2:0] OP_JOIN = 3'd1;
   localparam logic [2:0] OP_LEAVE = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_REPORT = 3'd4;
   localparam logic [2:0] OP_OTHER = 3'd5;

   // status codes
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_BAD_CSUM = 2'd3;

   // send kinds
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_LEAVE = 1'b1;

   // register indexes
   localparam logic CSR_INTERVAL = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] iface;
      logic [31:0] mcast_group;
      logic [7:0] resp_tenths;
      logic checksum_ok;
   } req_word_type;

   typedef struct packed {
      logic send_valid;
      logic send_kind;
      logic [3:0] send_iface;
      logic [31:0] send_group;
      logic [1:0] status;
      logic last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;     // latch request
      logic scan_start;   // reset scan index
      logic scan_step;    // process current row, advance index
      logic commit;       // join/leave single-row action on found/free row
      logic div_start;    // start delay modulo
      logic emit;         // emit final word
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_busy;
      logic arm_pending;  // row needs arming (query), or the join needs a delay at the end
   } ctl_stat_type;

endpackage
`default_nettype wire

/* rtl/igmp_host_group_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// IGMPv2 host group table. An event is taken when start is high and busy is
// low; the core then walks all TABLE_ROWS rows once, one per cycle unless a
// delay draw holds the scan. A delay is drawn in the bit-serial modulo unit
// for every query-matched row and for a join that finds a row; no LFSR value
// is drawn when the delay window is zero. Results appear on rsp_* for
// one cycle with rsp_strobe high and must be taken then: the receiver cannot
// stall. Ticks give one word per expiring row in row order; each is held
// until the next expiry is found, so the final one goes out at the end of the
// event with last set. The final word of every event carries last and comes
// in the first cycle in which busy is low again.
module igmp_host_group_table_core #(
   parameter int TABLE_ROWS = igmp_hgt_pkg::TableRowsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire igmp_hgt_pkg::req_word_type req_word,
   output logic rsp_strobe,
   output igmp_hgt_pkg::rsp_word_type rsp_word,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [31:0] csr_data
);
   igmp_hgt_pkg::ctl_cmd_type cmd;
   igmp_hgt_pkg::ctl_stat_type stat;

   igmp_hgt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   igmp_hgt_dp #(.TABLE_ROWS(TABLE_ROWS)) u_dp (
      .clock(clock), .reset(reset), .req_word(req_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .stat(stat), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );
endmodule
`default_nettype wire

/* rtl/igmp_hgt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module igmp_hgt_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire igmp_hgt_pkg::ctl_stat_type stat,
   output igmp_hgt_pkg::ctl_cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INIT = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_FIN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.scan_start = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_FIN;
            end else if (stat.arm_pending) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_DIV: begin
            if (!stat.div_busy) begin
               cmd.scan_step = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_FIN: begin
            if (stat.arm_pending) begin
               cmd.div_start = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.commit = 1'b1;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (!stat.div_busy) begin
               cmd.commit = 1'b1;
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/igmp_hgt_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module igmp_hgt_dp #(
   parameter int TABLE_ROWS = igmp_hgt_pkg::TableRowsDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire igmp_hgt_pkg::req_word_type req_word,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [31:0] csr_data,
   input wire igmp_hgt_pkg::ctl_cmd_type cmd,
   output igmp_hgt_pkg::ctl_stat_type stat,
   output logic rsp_strobe,
   output igmp_hgt_pkg::rsp_word_type rsp_word
);
   localparam int IW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   localparam int CW = $clog2(TABLE_ROWS + 1);
   localparam logic [CW-1:0] LastRow = CW'(TABLE_ROWS - 1);

   igmp_hgt_pkg::req_word_type req_ff;
   logic [15:0] interval_ff;
   logic [31:0] lfsr_ff, lfsr_in;

   logic [TABLE_ROWS-1:0] valid_ff, dly_ff, lastrep_ff;
   logic [3:0] iface_ff [TABLE_ROWS];
   logic [31:0] group_ff [TABLE_ROWS];
   logic [15:0] cnt_ff [TABLE_ROWS];

   logic [CW-1:0] idx_ff;
   logic [IW-1:0] row;
   logic [3:0] nexp_ff;
   logic found_ff, free_ff;
   logic [IW-1:0] found_idx_ff, free_idx_ff;

   // modulo unit, one quotient bit a cycle
   logic [31:0] dividend_ff;
   logic [15:0] rem_ff;
   logic [15:0] window_ff;
   logic [5:0] div_cnt_ff;
   logic div_busy;
   logic [16:0] rem_shift;

   logic scan_done, match, is_tick, is_join, is_leave, is_query, is_report;
   logic bad_group, csum_drop, row_arm, row_exp, fin_arm;
   logic [15:0] cur_cnt, cnt_dec, query_win, use_win;
   logic [14:0] mrt_prod;
   logic [IW-1:0] tgt;

   // expiry word held back until it is known whether it is the final one
   logic last_pending_ff;
   igmp_hgt_pkg::rsp_word_type held_word_ff;

   assign row = idx_ff[IW-1:0];
   assign scan_done = (idx_ff > LastRow);
   assign is_tick = (req_ff.op == igmp_hgt_pkg::OP_TICK);
   assign is_join = (req_ff.op == igmp_hgt_pkg::OP_JOIN);
   assign is_leave = (req_ff.op == igmp_hgt_pkg::OP_LEAVE);
   assign is_query = (req_ff.op == igmp_hgt_pkg::OP_QUERY);
   assign is_report = (req_ff.op == igmp_hgt_pkg::OP_REPORT);
   assign bad_group = (req_ff.mcast_group == igmp_hgt_pkg::AllHostsGroup)
      || (req_ff.mcast_group == '0);
   assign csum_drop = !req_ff.checksum_ok && !is_tick && !is_join && !is_leave;
   assign match = valid_ff[row] && (iface_ff[row] == req_ff.iface)
      && (group_ff[row] == req_ff.mcast_group);

   // query window: mrt*100, zero falls back to the interval
   assign mrt_prod = 15'(req_ff.resp_tenths) * 15'(igmp_hgt_pkg::RespUnit);
   assign query_win = (mrt_prod == '0) ? interval_ff : 16'(mrt_prod);
   assign use_win = is_query ? query_win : interval_ff;

   // per-row scan decisions
   assign cur_cnt = cnt_ff[row];
   assign cnt_dec = (cur_cnt != '0) ? cur_cnt - 16'd1 : cur_cnt;
   assign row_exp = is_tick && valid_ff[row] && dly_ff[row] && (cnt_dec == '0)
      && (nexp_ff != 4'(igmp_hgt_pkg::MaxResults));
   assign row_arm = is_query && req_ff.checksum_ok && valid_ff[row]
      && (iface_ff[row] == req_ff.iface)
      && ((req_ff.mcast_group == '0) || (group_ff[row] == req_ff.mcast_group));
   assign fin_arm = is_join && !bad_group && (found_ff || free_ff);
   assign tgt = found_ff ? found_idx_ff : free_idx_ff;

   assign div_busy = (div_cnt_ff != '0);
   assign stat.scan_done = scan_done;
   assign stat.div_busy = div_busy;
   assign stat.arm_pending = scan_done ? fin_arm : row_arm;

   assign rem_shift = {rem_ff, dividend_ff[31]};

   // galois lfsr step
   always_comb begin
      lfsr_in = {1'b0, lfsr_ff[31:1]};
      if (lfsr_ff[0]) begin
         lfsr_in = lfsr_in ^ igmp_hgt_pkg::LfsrTaps;
      end
   end

   // delay result compared against the running countdown
   function automatic logic keep_cnt(logic d, logic [15:0] c, logic [15:0] dl);
      keep_cnt = d && (c != '0) && (dl >= c);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dly_ff <= '0;
         lastrep_ff <= '0;
         interval_ff <= igmp_hgt_pkg::IntervalReset;
         lfsr_ff <= igmp_hgt_pkg::SeedReset;
         div_cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         // request latch and scan index
         if (cmd.load_req) begin
            req_ff <= req_word;
            nexp_ff <= '0;
            found_ff <= 1'b0;
            free_ff <= 1'b0;
         end
         if (cmd.scan_start) begin
            idx_ff <= '0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.scan_step && !scan_done) begin
            if (match && !found_ff) begin
               found_ff <= 1'b1;
               found_idx_ff <= row;
            end
            if (!valid_ff[row] && !free_ff) begin
               free_ff <= 1'b1;
               free_idx_ff <= row;
            end
         end

         // modulo: start draws lfsr unless the window is zero, then 32 restoring steps
         if (cmd.div_start) begin
            if (use_win == '0) begin
               div_cnt_ff <= '0;
               rem_ff <= '0;
            end else begin
               lfsr_ff <= lfsr_in;
               dividend_ff <= lfsr_in;
               rem_ff <= '0;
               div_cnt_ff <= 6'd32;
            end
            window_ff <= use_win;
         end else if (div_busy) begin
            dividend_ff <= {dividend_ff[30:0], 1'b0};
            div_cnt_ff <= div_cnt_ff - 6'd1;
            if (rem_shift >= {1'b0, window_ff}) begin
               rem_ff <= 16'(rem_shift - {1'b0, window_ff});
            end else begin
               rem_ff <= rem_shift[15:0];
            end
         end

         // query arm applied when the draw finishes on this row
         if (cmd.scan_step && !scan_done && row_arm) begin
            if (!keep_cnt(dly_ff[row], cnt_ff[row], rem_ff[15:0])) begin
               dly_ff[row] <= 1'b1;
               cnt_ff[row] <= rem_ff[15:0];
            end
         end

         // tick countdown
         if (cmd.scan_step && !scan_done && is_tick && valid_ff[row]
               && dly_ff[row]) begin
            cnt_ff[row] <= cnt_dec;
            if (row_exp) begin
               dly_ff[row] <= 1'b0;
               lastrep_ff[row] <= 1'b1;
               nexp_ff <= nexp_ff + 4'd1;
            end
         end

         // report cancels delay and clears the last-reporter flag
         if (cmd.scan_step && !scan_done && is_report && req_ff.checksum_ok && match
               && !found_ff) begin
            dly_ff[row] <= 1'b0;
            lastrep_ff[row] <= 1'b0;
         end

         // join/leave on the found or free row
         if (cmd.commit && !bad_group) begin
            if (is_join && (found_ff || free_ff)) begin
               valid_ff[tgt] <= 1'b1;
               iface_ff[tgt] <= req_ff.iface;
               group_ff[tgt] <= req_ff.mcast_group;
               lastrep_ff[tgt] <= 1'b1;
               if (found_ff && keep_cnt(dly_ff[tgt], cnt_ff[tgt], rem_ff[15:0])) begin
                  dly_ff[tgt] <= 1'b1;
               end else begin
                  dly_ff[tgt] <= 1'b1;
                  cnt_ff[tgt] <= rem_ff[15:0];
               end
            end else if (is_leave && found_ff) begin
               valid_ff[found_idx_ff] <= 1'b0;
               dly_ff[found_idx_ff] <= 1'b0;
               lastrep_ff[found_idx_ff] <= 1'b0;
               cnt_ff[found_idx_ff] <= '0;
            end
         end

         // configuration writes
         if (csr_write) begin
            if (csr_index == igmp_hgt_pkg::CSR_INTERVAL) begin
               interval_ff <= csr_data[15:0];
            end else begin
               lfsr_ff <= (csr_data == '0) ? 32'd1 : csr_data;
            end
         end
      end
   end

   // result strobe: a held expiry goes out when the next one arrives,
   // the final word at emit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
         last_pending_ff <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         if (cmd.scan_step && !scan_done && row_exp) begin
            rsp_strobe <= last_pending_ff;
            last_pending_ff <= 1'b1;
         end else if (cmd.emit) begin
            rsp_strobe <= 1'b1;
            last_pending_ff <= 1'b0;
         end
      end
   end

   // result word: expiry reports during the scan, final word at commit
   always_ff @(posedge clock) begin
      if (cmd.scan_step && !scan_done && row_exp) begin
         rsp_word <= held_word_ff;
         held_word_ff <= '{1'b1, igmp_hgt_pkg::KIND_REPORT, iface_ff[row], group_ff[row],
                           igmp_hgt_pkg::ST_DONE, 1'b0};
      end else if (cmd.emit) begin
         if (is_tick) begin
            if (last_pending_ff) begin
               rsp_word <= '{held_word_ff.send_valid, held_word_ff.send_kind,
                             held_word_ff.send_iface, held_word_ff.send_group,
                             held_word_ff.status, 1'b1};
            end else begin
               rsp_word <= '{1'b0, 1'b0, 4'd0, 32'd0, igmp_hgt_pkg::ST_DONE, 1'b1};
            end
         end else if ((is_join || is_leave) && bad_group) begin
            rsp_word <= '{1'b0, 1'b0, 4'd0, 32'd0, igmp_hgt_pkg::ST_IGNORED, 1'b1};
         end else if (is_join && !(found_ff || free_ff)) begin
            rsp_word <= '{1'b0, 1'b0, 4'd0, 32'd0, igmp_hgt_pkg::ST_FULL, 1'b1};
         end else if (is_join) begin
            rsp_word <= '{1'b1, igmp_hgt_pkg::KIND_REPORT, req_ff.iface,
                          req_ff.mcast_group, igmp_hgt_pkg::ST_DONE, 1'b1};
         end else if (is_leave && found_ff && lastrep_ff[found_idx_ff]) begin
            rsp_word <= '{1'b1, igmp_hgt_pkg::KIND_LEAVE, req_ff.iface,
                          req_ff.mcast_group, igmp_hgt_pkg::ST_DONE, 1'b1};
         end else if (csum_drop) begin
            rsp_word <= '{1'b0, 1'b0, 4'd0, 32'd0, igmp_hgt_pkg::ST_BAD_CSUM, 1'b1};
         end else begin
            rsp_word <= '{1'b0, 1'b0, 4'd0, 32'd0, igmp_hgt_pkg::ST_DONE, 1'b1};
         end
      end
   end
endmodule
`default_nettype wire

/* tb/igmp_hgt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module igmp_hgt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire igmp_hgt_pkg::req_word_type req_word,
   input wire logic rsp_strobe,
   input wire igmp_hgt_pkg::rsp_word_type rsp_word,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [31:0] csr_data,
   output int pending,
   output int fail_count
);

   localparam int Rows = igmp_hgt_pkg::TableRowsDefault;

   // shadow copy of the group table and its settings
   logic [15:0] interval_ms;
   logic [31:0] lfsr_q;
   logic row_used [Rows];
   logic [3:0] row_if [Rows];
   logic [31:0] row_grp [Rows];
   logic row_delay [Rows];
   logic row_lastrep [Rows];
   logic [15:0] row_count [Rows];

   igmp_hgt_pkg::rsp_word_type expected_words[$];

   assign pending = expected_words.size();

   function automatic igmp_hgt_pkg::rsp_word_type make_word(logic v, logic k,
         logic [3:0] i, logic [31:0] g, logic [1:0] s, logic l);
      igmp_hgt_pkg::rsp_word_type w;
      w.send_valid = v;
      w.send_kind = k;
      w.send_iface = i;
      w.send_group = g;
      w.status = s;
      w.last = l;
      return w;
   endfunction

   // galois lfsr step, delay is the new value mod window
   function automatic logic [31:0] draw_delay(logic [31:0] window);
      logic lsb;
      if (window == 0) return 0;
      lsb = lfsr_q[0];
      lfsr_q = lfsr_q >> 1;
      if (lsb) lfsr_q = lfsr_q ^ igmp_hgt_pkg::LfsrTaps;
      return lfsr_q % window;
   endfunction

   // re-arm only when sooner, overdue rows always
   function automatic void arm_row(int r, logic [31:0] window);
      logic [31:0] d;
      d = draw_delay(window);
      if (row_delay[r] && row_count[r] > 0 && d >= row_count[r]) return;
      row_delay[r] = 1'b1;
      row_count[r] = d[15:0];
   endfunction

   function automatic int find_row(logic [3:0] i, logic [31:0] g);
      for (int r = 0; r < Rows; r++)
         if (row_used[r] && row_if[r] == i && row_grp[r] == g) return r;
      return -1;
   endfunction

   function automatic void clear_row(int r);
      row_used[r] = 0;
      row_if[r] = 0;
      row_grp[r] = 0;
      row_delay[r] = 0;
      row_lastrep[r] = 0;
      row_count[r] = 0;
   endfunction

   function automatic void predict_event(igmp_hgt_pkg::req_word_type w);
      int r;
      int n;
      logic [31:0] window;
      case (w.op)
         igmp_hgt_pkg::OP_TICK: begin
            n = 0;
            for (int i = 0; i < Rows; i++) begin
               if (!row_used[i] || !row_delay[i]) continue;
               if (row_count[i] > 0) row_count[i]--;
               if (row_count[i] == 0 && n < igmp_hgt_pkg::MaxResults) begin
                  row_delay[i] = 0;
                  row_lastrep[i] = 1;
                  expected_words.push_back(make_word(1'b1, igmp_hgt_pkg::KIND_REPORT,
                        row_if[i], row_grp[i], igmp_hgt_pkg::ST_DONE, 1'b0));
                  n++;
               end
            end
            if (n == 0)
               expected_words.push_back(make_word(0, 0, 0, 0, igmp_hgt_pkg::ST_DONE, 1));
            else expected_words[$].last = 1'b1;
         end
         igmp_hgt_pkg::OP_JOIN, igmp_hgt_pkg::OP_LEAVE: begin
            if (w.mcast_group == igmp_hgt_pkg::AllHostsGroup || w.mcast_group == 0) begin
               expected_words.push_back(make_word(0, 0, 0, 0, igmp_hgt_pkg::ST_IGNORED, 1));
               return;
            end
            r = find_row(w.iface, w.mcast_group);
            if (w.op == igmp_hgt_pkg::OP_JOIN) begin
               if (r < 0) begin
                  for (int i = 0; i < Rows; i++)
                     if (!row_used[i]) begin
                        r = i;
                        clear_row(i);
                        row_used[i] = 1;
                        row_if[i] = w.iface;
                        row_grp[i] = w.mcast_group;
                        break;
                     end
               end
               if (r < 0) begin
                  expected_words.push_back(make_word(0, 0, 0, 0, igmp_hgt_pkg::ST_FULL, 1));
                  return;
               end
               row_lastrep[r] = 1;
               arm_row(r, {16'd0, interval_ms});
               expected_words.push_back(make_word(1, igmp_hgt_pkg::KIND_REPORT, w.iface,
                     w.mcast_group, igmp_hgt_pkg::ST_DONE, 1));
            end else if (r >= 0 && row_lastrep[r]) begin
               clear_row(r);
               expected_words.push_back(make_word(1, igmp_hgt_pkg::KIND_LEAVE, w.iface,
                     w.mcast_group, igmp_hgt_pkg::ST_DONE, 1));
            end else begin
               if (r >= 0) clear_row(r);
               expected_words.push_back(make_word(0, 0, 0, 0, igmp_hgt_pkg::ST_DONE, 1));
            end
         end
         default: begin
            if (!w.checksum_ok) begin
               expected_words.push_back(make_word(0, 0, 0, 0, igmp_hgt_pkg::ST_BAD_CSUM, 1));
               return;
            end
            if (w.op == igmp_hgt_pkg::OP_QUERY) begin
               window = w.resp_tenths * igmp_hgt_pkg::RespUnit;
               if (window == 0) window = {16'd0, interval_ms};
               for (int i = 0; i < Rows; i++) begin
                  if (!row_used[i] || row_if[i] != w.iface) continue;
                  if (w.mcast_group == 0 || w.mcast_group == row_grp[i]) arm_row(i, window);
               end
            end else if (w.op == igmp_hgt_pkg::OP_REPORT) begin
               r = find_row(w.iface, w.mcast_group);
               if (r >= 0) begin
                  row_delay[r] = 0;
                  row_lastrep[r] = 0;
               end
            end
            expected_words.push_back(make_word(0, 0, 0, 0, igmp_hgt_pkg::ST_DONE, 1));
         end
      endcase
   endfunction

   // compare results first, then predict the newly accepted word
   always @(posedge clock) begin
      igmp_hgt_pkg::rsp_word_type want;
      if (reset) begin
         interval_ms = igmp_hgt_pkg::IntervalReset;
         lfsr_q = igmp_hgt_pkg::SeedReset;
         for (int i = 0; i < Rows; i++) clear_row(i);
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected word %p", rsp_word);
            end else begin
               want = expected_words.pop_front();
               if (want !== rsp_word) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p got %p", want, rsp_word);
               end
            end
         end
         if (start && !busy) predict_event(req_word);
         if (csr_write) begin
            if (csr_index == igmp_hgt_pkg::CSR_INTERVAL) interval_ms = csr_data[15:0];
            else lfsr_q = (csr_data == 0) ? 32'd1 : csr_data;
         end
      end
   end

endmodule
`default_nettype wire

/* tb/igmp_host_group_table_core_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module igmp_host_group_table_core_tb;

   localparam int StallLimit = 6000;
   localparam int DrainCycles = 400;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   igmp_hgt_pkg::req_word_type req_word = '0;
   logic rsp_strobe;
   igmp_hgt_pkg::rsp_word_type rsp_word;
   logic csr_write = 0;
   logic csr_index = igmp_hgt_pkg::CSR_INTERVAL;
   logic [31:0] csr_data = 0;
   int pending;
   int fail_count;
   int stall_cycles = 0;
   int burst_left = 0;
   logic [31:0] group_pool [10];

   igmp_host_group_table_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   igmp_hgt_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .pending(pending),
      .fail_count(fail_count)
   );

   always #4 clock = ~clock;

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one word, random gap before it, stretches without gaps
   task automatic send_word(logic [2:0] op, logic [3:0] ifc, logic [31:0] grp,
                            logic [7:0] mrt, logic ok);
      int gap;
      igmp_hgt_pkg::req_word_type w;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 19);
         if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
      end
      w.op = op;
      w.iface = ifc;
      w.mcast_group = grp;
      w.resp_tenths = mrt;
      w.checksum_ok = ok;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_word <= w;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // wait until every expected word is in and the core has settled
   task automatic drain();
      start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] data);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 0;
   endtask

   // mostly well-formed traffic on a few interfaces and groups, some noise
   task automatic random_phase(int count);
      int sel;
      logic [3:0] ifc;
      logic [31:0] grp;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         ifc = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
         grp = ($urandom_range(0, 9) == 0) ? $urandom : group_pool[$urandom_range(0, 9)];
         if (sel < 35)
            send_word(igmp_hgt_pkg::OP_TICK, 4'($urandom), $urandom, 8'($urandom),
                      1'($urandom));
         else if (sel < 55)
            send_word(igmp_hgt_pkg::OP_JOIN, ifc, grp, 8'($urandom), 1'($urandom));
         else if (sel < 67)
            send_word(igmp_hgt_pkg::OP_LEAVE, ifc, grp, 8'($urandom), 1'($urandom));
         else if (sel < 80)
            send_word(igmp_hgt_pkg::OP_QUERY, ifc, ($urandom_range(0, 2) == 0) ? 32'd0 : grp,
                      ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 3)),
                      $urandom_range(0, 9) != 0);
         else if (sel < 90)
            send_word(igmp_hgt_pkg::OP_REPORT, ifc, grp, 8'($urandom),
                      $urandom_range(0, 9) != 0);
         else send_word(3'($urandom_range(3, 7)), 4'($urandom), $urandom, 8'($urandom),
                        1'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < 10; i++) group_pool[i] = 32'hE000_0100 + i;
      group_pool[8] = 32'hEFFF_FFFF;
      group_pool[9] = $urandom | 32'h1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: short delays so expiries show up quickly
      write_csr(igmp_hgt_pkg::CSR_INTERVAL, 32'd3);
      write_csr(igmp_hgt_pkg::CSR_SEED, $urandom);
      send_word(igmp_hgt_pkg::OP_JOIN, 4'd0, igmp_hgt_pkg::AllHostsGroup, 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_JOIN, 4'd15, 32'd0, 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_LEAVE, 4'd0, igmp_hgt_pkg::AllHostsGroup, 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_LEAVE, 4'd3, 32'hE000_0999, 8'd0, 1);
      for (int i = 0; i < 8; i++)
         send_word(igmp_hgt_pkg::OP_JOIN, 4'(i), group_pool[i], 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_JOIN, 4'd15, 32'hFFFF_FFFF, 8'hFF, 1);
      send_word(igmp_hgt_pkg::OP_JOIN, 4'd1, group_pool[1], 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_REPORT, 4'd0, group_pool[0], 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_LEAVE, 4'd0, group_pool[0], 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_QUERY, 4'd1, 32'd0, 8'd0, 1);
      send_word(igmp_hgt_pkg::OP_QUERY, 4'd2, group_pool[2], 8'hFF, 1);
      send_word(igmp_hgt_pkg::OP_QUERY, 4'd3, 32'd0, 8'd1, 0);
      send_word(igmp_hgt_pkg::OP_REPORT, 4'd4, group_pool[4], 8'd0, 0);
      send_word(igmp_hgt_pkg::OP_OTHER, 4'd5, 32'd0, 8'd0, 0);
      send_word(3'd6, 4'd5, 32'h1234_5678, 8'd7, 1);
      send_word(3'd7, 4'd5, 32'h8765_4321, 8'd9, 1);
      send_word(igmp_hgt_pkg::OP_REPORT, 4'd0, 32'd0, 8'd0, 1);
      repeat (4) send_word(igmp_hgt_pkg::OP_TICK, 4'd0, 32'd0, 8'd0, 0);

      // random phases under different settings, extremes included
      drain();
      write_csr(igmp_hgt_pkg::CSR_SEED, 32'd0);
      random_phase(45);
      drain();
      write_csr(igmp_hgt_pkg::CSR_INTERVAL, 32'd0);
      write_csr(igmp_hgt_pkg::CSR_SEED, 32'hFFFF_FFFF);
      random_phase(45);
      drain();
      write_csr(igmp_hgt_pkg::CSR_INTERVAL, 32'hFFFF);
      write_csr(igmp_hgt_pkg::CSR_SEED, $urandom);
      random_phase(25);
      drain();
      write_csr(igmp_hgt_pkg::CSR_INTERVAL, 32'd5);
      random_phase(25);

      drain();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

/* igmp_host_group_table_core.f */
rtl/igmp_hgt_pkg.sv
rtl/igmp_hgt_ctrl.sv
rtl/igmp_hgt_dp.sv
rtl/igmp_host_group_table_core.sv
tb/igmp_hgt_checker.sv
tb/igmp_host_group_table_core_tb.sv
